@@ rtl/bcd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bcd_pkg;

  // block difference modes, encoded as the diff_mode register value
  typedef enum logic [1:0] {
    MODE_MAX   = 2'd0,
    MODE_MEAN  = 2'd1,
    MODE_EXACT = 2'd2,
    MODE_QMEAN = 2'd3
  } diff_mode_t;

  // configuration register indexes
  localparam logic [1:0] CFG_DIFF_MODE = 2'd0;
  localparam logic [1:0] CFG_MAX_DIFF  = 2'd1;

  // fixed field widths
  localparam int CHAN_W   = 8;
  localparam int SAD_W    = 10;  // |dR|+|dG|+|dB| up to 765
  localparam int TERM_W   = 20;  // square of the pixel difference
  localparam int ACC_W    = 26;
  localparam int COUNT_W  = 7;
  localparam int BOUND_W  = 28;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam logic [1:0]       MODE_RESET = 2'd3;
  localparam logic [SAD_W-1:0] MAX_DIFF_RESET = 10'd192;

  // one classified pixel handed from the front end to the back end
  typedef struct packed {
    logic [SAD_W-1:0] sad;
    logic             exceed;
    logic             differ;
    logic             last;
  } item_t;

endpackage
`default_nettype wire

@@ rtl/bcd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bcd_front (
  input  wire logic [47:0]                  pix_data,
  input  wire logic                         pix_last,
  input  wire logic [bcd_pkg::SAD_W-1:0]    max_diff,
  output bcd_pkg::item_t                    item
);

  logic [bcd_pkg::CHAN_W-1:0] cur_r, cur_g, cur_b, prev_r, prev_g, prev_b;
  logic [bcd_pkg::CHAN_W-1:0] ad_r, ad_g, ad_b;
  logic [bcd_pkg::SAD_W-1:0]  sad;

  // unpack the colour bytes, red in the lowest bits
  assign cur_r  = pix_data[7:0];
  assign cur_g  = pix_data[15:8];
  assign cur_b  = pix_data[23:16];
  assign prev_r = pix_data[31:24];
  assign prev_g = pix_data[39:32];
  assign prev_b = pix_data[47:40];

  // absolute channel differences
  assign ad_r = (cur_r > prev_r) ? (cur_r - prev_r) : (prev_r - cur_r);
  assign ad_g = (cur_g > prev_g) ? (cur_g - prev_g) : (prev_g - cur_g);
  assign ad_b = (cur_b > prev_b) ? (cur_b - prev_b) : (prev_b - cur_b);

  assign sad = bcd_pkg::SAD_W'(ad_r) + bcd_pkg::SAD_W'(ad_g) + bcd_pkg::SAD_W'(ad_b);

  // classify the pixel
  always_comb begin
    item.sad    = sad;
    item.exceed = (sad > max_diff);
    item.differ = (pix_data[23:0] != pix_data[47:24]);
    item.last   = pix_last;
  end

endmodule
`default_nettype wire

@@ rtl/bcd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bcd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bcd_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output bcd_pkg::item_t      pop_item,
  output logic                not_empty
);

  localparam int PtrW = $clog2(bcd_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(bcd_pkg::QUEUE_DEPTH + 1);

  bcd_pkg::item_t entries [bcd_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push, do_pop;

  assign full      = (fill == CntW'(bcd_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/bcd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bcd_back #(
  parameter int BLOCK_EDGE = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire bcd_pkg::item_t                q_item,
  output logic                               q_pop,
  input  wire bcd_pkg::diff_mode_t           diff_mode,
  input  wire logic [bcd_pkg::SAD_W-1:0]     max_diff,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_changed,
  output logic [bcd_pkg::COUNT_W-1:0]        out_pixels
);

  localparam int CapRaw = BLOCK_EDGE * BLOCK_EDGE;
  localparam int Cap = (CapRaw > 127) ? 127 : ((CapRaw < 1) ? 1 : CapRaw);
  localparam logic [bcd_pkg::COUNT_W-1:0] CapN = bcd_pkg::COUNT_W'(Cap);

  logic en;

  // term stage
  logic                         a_valid, a_exceed, a_differ, a_last;
  logic [bcd_pkg::TERM_W-1:0]   a_term, term_next;

  // accumulate stage
  logic [bcd_pkg::ACC_W-1:0]    acc;
  logic [bcd_pkg::COUNT_W-1:0]  cnt;
  logic                         exceed_acc, differ_acc;
  logic [bcd_pkg::ACC_W:0]      sum;
  logic [bcd_pkg::ACC_W-1:0]    acc_sat;
  logic [bcd_pkg::COUNT_W-1:0]  n;
  logic                         close_block;
  logic                         b_valid, b_exceed, b_differ;
  logic [bcd_pkg::ACC_W-1:0]    b_acc;
  logic [bcd_pkg::COUNT_W-1:0]  b_n;

  // bound stage
  logic [bcd_pkg::TERM_W-1:0]   max_sq;
  logic [bcd_pkg::TERM_W:0]     thr1;
  logic                         c_valid, c_exceed, c_differ;
  logic [bcd_pkg::ACC_W-1:0]    c_acc;
  logic [bcd_pkg::COUNT_W-1:0]  c_n;
  logic [bcd_pkg::BOUND_W-1:0]  c_bound;
  logic                         changed;

  // the whole back end moves when the output register can take a result
  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid;

  // per-pixel term for the selected mode
  always_comb begin
    case (diff_mode)
      bcd_pkg::MODE_QMEAN: term_next = bcd_pkg::TERM_W'(q_item.sad) *
                                       bcd_pkg::TERM_W'(q_item.sad);
      bcd_pkg::MODE_MEAN:  term_next = bcd_pkg::TERM_W'(q_item.sad);
      default:             term_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_term   <= term_next;
      a_exceed <= q_item.exceed;
      a_differ <= q_item.differ;
      a_last   <= q_item.last;
    end
  end

  // saturating accumulation and block close
  assign sum         = {1'b0, acc} + (bcd_pkg::ACC_W + 1)'(a_term);
  assign acc_sat     = sum[bcd_pkg::ACC_W] ? bcd_pkg::ACC_MAX : sum[bcd_pkg::ACC_W-1:0];
  assign n           = cnt + 1'b1;
  assign close_block = a_last || (n >= CapN);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      cnt        <= '0;
      exceed_acc <= 1'b0;
      differ_acc <= 1'b0;
      b_valid    <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid && close_block;
      if (a_valid) begin
        if (close_block) begin
          acc        <= '0;
          cnt        <= '0;
          exceed_acc <= 1'b0;
          differ_acc <= 1'b0;
        end else begin
          acc        <= acc_sat;
          cnt        <= n;
          exceed_acc <= exceed_acc | a_exceed;
          differ_acc <= differ_acc | a_differ;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_acc    <= acc_sat;
      b_n      <= n;
      b_exceed <= exceed_acc | a_exceed;
      b_differ <= differ_acc | a_differ;
    end
  end

  // squared threshold, follows the register
  always_ff @(posedge clk) begin
    max_sq <= bcd_pkg::TERM_W'(max_diff) * bcd_pkg::TERM_W'(max_diff);
  end

  // floor(acc / n) > thr  is the same as  acc >= (thr + 1) * n
  assign thr1 = (diff_mode == bcd_pkg::MODE_QMEAN)
                ? ({1'b0, max_sq} + 1'b1)
                : ((bcd_pkg::TERM_W + 1)'(max_diff) + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_bound  <= bcd_pkg::BOUND_W'(thr1) * bcd_pkg::BOUND_W'(b_n);
      c_acc    <= b_acc;
      c_n      <= b_n;
      c_exceed <= b_exceed;
      c_differ <= b_differ;
    end
  end

  // decision under the mode at block end
  always_comb begin
    unique case (diff_mode)
      bcd_pkg::MODE_MAX:   changed = c_exceed;
      bcd_pkg::MODE_EXACT: changed = c_differ;
      default:             changed = (bcd_pkg::BOUND_W'(c_acc) >= c_bound);
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && c_valid) begin
      out_changed <= changed;
      out_pixels  <= c_n;
    end
  end

endmodule
`default_nettype wire

@@ rtl/block_change_detector.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one pixel pair per cycle, held as long as the result side keeps up.
// Path: after its last pixel transfer, a block result passes the queue, then the registers
// for term multiply, accumulate, threshold multiply and the output register.
// A four-entry queue splits pixel classification from the accumulate pipeline.
// Reset (rst, synchronous): diff_mode 3, max_diff 192, empty queue, block state cleared.
module block_change_detector #(
  parameter int BLOCK_EDGE = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // cur_red, cur_green, cur_blue, prev_red, prev_green, prev_blue (8 bits each)
  input  wire logic [47:0] s_tdata,
  input  wire logic        s_tlast,   // last_of_block
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // block_changed [0], block_pixels [7:1]
  output logic [7:0]       m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  bcd_pkg::diff_mode_t            diff_mode;
  logic [bcd_pkg::SAD_W-1:0]      max_diff;
  bcd_pkg::item_t                 front_item, q_item;
  logic                           q_full, q_pop, q_valid;
  logic                           out_changed;
  logic [bcd_pkg::COUNT_W-1:0]    out_pixels;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_mode <= bcd_pkg::diff_mode_t'(bcd_pkg::MODE_RESET);
      max_diff  <= bcd_pkg::MAX_DIFF_RESET;
    end else if (cfg_we) begin
      if (cfg_index == bcd_pkg::CFG_DIFF_MODE) begin
        diff_mode <= bcd_pkg::diff_mode_t'(cfg_data[1:0]);
      end else if (cfg_index == bcd_pkg::CFG_MAX_DIFF) begin
        max_diff <= cfg_data;
      end
    end
  end

  // pixel classification
  bcd_front u_front (
    .pix_data (s_tdata),
    .pix_last (s_tlast),
    .max_diff (max_diff),
    .item     (front_item)
  );

  assign s_tready = !q_full;

  // queue between front and back
  bcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_valid)
  );

  // accumulation and decision
  bcd_back #(
    .BLOCK_EDGE (BLOCK_EDGE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .diff_mode   (diff_mode),
    .max_diff    (max_diff),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_changed (out_changed),
    .out_pixels  (out_pixels)
  );

  assign m_tdata = {out_pixels, out_changed};

`ifndef SYNTH
  // a finished block always holds at least one pixel
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> (m_tdata[7:1] != '0))
    else $error("block result with zero pixels");

  // block size never exceeds the capacity
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (int'(m_tdata[7:1]) <= BLOCK_EDGE * BLOCK_EDGE))
    else $error("block result larger than block capacity");

  // the queue is empty right after reset
  assert property (@(posedge clk) $past(rst) |-> s_tready)
    else $error("input not ready after reset");
`endif

endmodule
`default_nettype wire

@@ tb/block_change_checker.sv @@
`timescale 1ns / 1ps
module block_change_checker #(
  parameter int BLOCK_EDGE = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  // cur_red, cur_green, cur_blue, prev_red, prev_green, prev_blue (8 bits each)
  input  wire logic [47:0] s_tdata,
  input  wire logic        s_tlast,   // last_of_block
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  // block_changed [0], block_pixels [7:1]
  input  wire logic [7:0]  m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data,
  output int               fail_count,
  output int               outstanding
);

  localparam int EDGE_AREA = BLOCK_EDGE * BLOCK_EDGE;
  localparam int BLOCK_CAP = (EDGE_AREA > 127) ? 127 : ((EDGE_AREA < 1) ? 1 : EDGE_AREA);

  // same layout as m_tdata
  typedef struct packed {
    logic [6:0] pixels;
    logic       changed;
  } block_verdict_t;

  block_verdict_t expected_verdicts[$];

  // predicted block state and registers
  bcd_pkg::diff_mode_t active_mode = bcd_pkg::MODE_QMEAN;
  logic [9:0]  active_threshold = bcd_pkg::MAX_DIFF_RESET;
  logic [25:0] gap_total = '0;
  logic [6:0]  pixels_open = '0;
  logic        any_exceed = 1'b0;
  logic        any_differ = 1'b0;

  initial fail_count = 0;
  initial outstanding = 0;

  function automatic logic [9:0] channel_gap(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? 10'(a - b) : 10'(b - a);
  endfunction

  task automatic clear_open_block();
    gap_total = '0;
    pixels_open = '0;
    any_exceed = 1'b0;
    any_differ = 1'b0;
  endtask

  // fold one pixel pair into the open block, queue a verdict when it closes
  task automatic fold_pixel(input logic [47:0] pair, input logic closing_mark);
    logic [9:0]     gap;
    logic [63:0]    wide_gap;
    logic [63:0]    sum;
    logic [63:0]    mean_val;
    logic [63:0]    bound;
    logic [7:0]     count_next;
    block_verdict_t verdict;
    gap = channel_gap(pair[7:0], pair[31:24]) + channel_gap(pair[15:8], pair[39:32])
        + channel_gap(pair[23:16], pair[47:40]);
    if (pair[23:0] != pair[47:24]) any_differ = 1'b1;
    if (gap > active_threshold) any_exceed = 1'b1;
    // mean adds the gap, squared mean its square, the others nothing
    wide_gap = 64'(gap);
    sum = 64'(gap_total);
    if (active_mode == bcd_pkg::MODE_MEAN) sum = sum + wide_gap;
    else if (active_mode == bcd_pkg::MODE_QMEAN) sum = sum + wide_gap * wide_gap;
    if (sum > 64'(bcd_pkg::ACC_MAX)) sum = 64'(bcd_pkg::ACC_MAX);
    gap_total = sum[25:0];
    count_next = {1'b0, pixels_open} + 8'd1;
    // block closes on its marker or by force at capacity
    if (!closing_mark && count_next < 8'(BLOCK_CAP)) begin
      pixels_open = count_next[6:0];
    end else begin
      mean_val = sum / 64'(count_next);
      bound = 64'(active_threshold);
      case (active_mode)
        bcd_pkg::MODE_MAX:   verdict.changed = any_exceed;
        bcd_pkg::MODE_MEAN:  verdict.changed = (mean_val > bound);
        bcd_pkg::MODE_EXACT: verdict.changed = any_differ;
        default:             verdict.changed = (mean_val > bound * bound);
      endcase
      verdict.pixels = count_next[6:0];
      expected_verdicts.push_back(verdict);
      clear_open_block();
    end
  endtask

  // watch register writes and both channels, compare each result transfer
  always @(posedge clk) begin : monitor
    block_verdict_t seen;
    block_verdict_t want;
    if (rst) begin
      active_mode = bcd_pkg::MODE_QMEAN;
      active_threshold = bcd_pkg::MAX_DIFF_RESET;
      clear_open_block();
      expected_verdicts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bcd_pkg::CFG_DIFF_MODE: active_mode = bcd_pkg::diff_mode_t'(cfg_data[1:0]);
          bcd_pkg::CFG_MAX_DIFF:  active_threshold = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        seen = m_tdata;
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          $error("result transfer with nothing expected: block_changed %0d block_pixels %0d",
                 seen.changed, seen.pixels);
        end else begin
          want = expected_verdicts.pop_front();
          if (seen.changed !== want.changed) begin
            fail_count++;
            $error("block_changed: expected %0d, actual %0d", want.changed, seen.changed);
          end
          if (seen.pixels !== want.pixels) begin
            fail_count++;
            $error("block_pixels: expected %0d, actual %0d", want.pixels, seen.pixels);
          end
        end
      end
      if (s_tvalid && s_tready) fold_pixel(s_tdata, s_tlast);
    end
    outstanding = expected_verdicts.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;

  localparam int BLOCK_EDGE     = 8;
  localparam int BLOCK_CAP      = BLOCK_EDGE * BLOCK_EDGE;
  localparam int SETTLE_CYCLES  = 12;
  localparam int STALL_LIMIT    = 4000;
  localparam int RANDOM_PIXELS  = 1240;
  localparam int SETTINGS_EACH  = 3;
  localparam int SETTING_PIXELS = RANDOM_PIXELS / (4 * SETTINGS_EACH);

  // indexes past the register list, writes there are ignored
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  // same layout as s_tdata, cur_red in the lowest byte
  typedef struct packed {
    logic [7:0] prev_blue;
    logic [7:0] prev_green;
    logic [7:0] prev_red;
    logic [7:0] cur_blue;
    logic [7:0] cur_green;
    logic [7:0] cur_red;
  } pixel_pair_t;

  typedef enum logic [2:0] {
    PAT_SAME,
    PAT_NEAR,
    PAT_WILD,
    PAT_EXTREME,
    PAT_ONE_BIT
  } pixel_pattern_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int fail_count;
  int outstanding;

  block_change_detector #(.BLOCK_EDGE(BLOCK_EDGE)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  block_change_checker #(.BLOCK_EDGE(BLOCK_EDGE)) i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  // result side backpressure
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("block_change_detector regression: fail");
      $finish;
    end
  end

  function automatic logic [7:0] nudge(input logic [7:0] base, input int spread);
    int shifted;
    if ($urandom_range(1) == 1) shifted = int'(base) + int'($urandom_range(spread));
    else shifted = int'(base) - int'($urandom_range(spread));
    if (shifted > 255) shifted = 255;
    if (shifted < 0) shifted = 0;
    return 8'(shifted);
  endfunction

  function automatic pixel_pair_t mk_pair(input logic [7:0] cr, input logic [7:0] cg,
                                          input logic [7:0] cb, input logic [7:0] pr,
                                          input logic [7:0] pg, input logic [7:0] pb);
    pixel_pair_t p;
    p.cur_red = cr;
    p.cur_green = cg;
    p.cur_blue = cb;
    p.prev_red = pr;
    p.prev_green = pg;
    p.prev_blue = pb;
    return p;
  endfunction

  function automatic pixel_pair_t draw_pair(input pixel_pattern_t pattern, input int spread);
    pixel_pair_t p;
    logic [5:0]  pick;
    {p.cur_blue, p.cur_green, p.cur_red} = 24'($urandom);
    {p.prev_blue, p.prev_green, p.prev_red} = 24'($urandom);
    pick = 6'($urandom);
    case (pattern)
      PAT_SAME: {p.prev_blue, p.prev_green, p.prev_red} = {p.cur_blue, p.cur_green, p.cur_red};
      PAT_NEAR: begin
        p.prev_red = nudge(p.cur_red, spread);
        p.prev_green = nudge(p.cur_green, spread);
        p.prev_blue = nudge(p.cur_blue, spread);
      end
      PAT_EXTREME: begin
        for (int k = 0; k < 6; k++) p[8*k +: 8] = pick[k] ? 8'hFF : 8'h00;
      end
      PAT_ONE_BIT: begin
        {p.prev_blue, p.prev_green, p.prev_red} =
          {p.cur_blue, p.cur_green, p.cur_red} ^ (24'd1 << $urandom_range(23));
      end
      default: ;
    endcase
    return p;
  endfunction

  // one pixel transfer, with random gaps in front of it
  task automatic send_pixel(input pixel_pair_t pair, input logic mark);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_tdata = pair;
    s_tlast = mark;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // wait until every result is in and the pipeline has drained
  task automatic settle();
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [9:0] value);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_block(input int length, input pixel_pattern_t pattern, input int spread,
                            input bit marked);
    for (int i = 0; i < length; i++)
      send_pixel(draw_pair(pattern, spread), marked && (i == length - 1));
  endtask

  // one block of random shape and content, mostly well formed
  task automatic random_block(output int sent);
    int             shape;
    int             spread;
    int             pick;
    pixel_pattern_t pattern;
    shape = $urandom_range(99);
    pick = $urandom_range(9);
    spread = ($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(255);
    case (pick)
      0: pattern = PAT_SAME;
      1: pattern = PAT_WILD;
      2: pattern = PAT_EXTREME;
      3: pattern = PAT_ONE_BIT;
      default: pattern = PAT_NEAR;
    endcase
    // now and then hold the stream until all results are back
    if ($urandom_range(99) < 2) begin
      while (outstanding != 0) @(negedge clk);
    end
    if (shape < 12) sent = 1;
    else if (shape < 22) sent = BLOCK_CAP;
    else if (shape < 30) sent = BLOCK_CAP + $urandom_range(1, 30);
    else if (shape < 38) sent = $urandom_range(1, 20);
    else sent = $urandom_range(2, 40);
    if (shape >= 22 && shape < 30) begin
      // overlong run with no marker, closes by force
      send_block(sent, pattern, spread, 1'b0);
    end else if (shape >= 30 && shape < 38) begin
      // noise: markers at random
      for (int i = 0; i < sent; i++)
        send_pixel(draw_pair(pattern, spread), $urandom_range(3) == 0);
    end else begin
      send_block(sent, pattern, spread, 1'b1);
    end
  endtask

  initial begin
    int         sent;
    int         setting_sent;
    int         mode_pick;
    logic [9:0] threshold;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed: reset settings are squared mean with threshold 192
    write_reg(CFG_SPARE_LO, 10'($urandom));
    write_reg(CFG_SPARE_HI, 10'($urandom));
    send_pixel(mk_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1);
    send_pixel(mk_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0), 1'b1);

    // max mode at both threshold extremes
    settle();
    write_reg(bcd_pkg::CFG_DIFF_MODE, 10'(bcd_pkg::MODE_MAX));
    write_reg(bcd_pkg::CFG_MAX_DIFF, 10'd0);
    send_pixel(mk_pair(8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd8), 1'b1);
    send_pixel(mk_pair(8'd200, 8'd100, 8'd50, 8'd200, 8'd100, 8'd50), 1'b1);
    settle();
    write_reg(bcd_pkg::CFG_MAX_DIFF, 10'd765);
    send_pixel(mk_pair(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0), 1'b1);

    // mean mode, largest difference against the top threshold, then truncation
    settle();
    write_reg(bcd_pkg::CFG_DIFF_MODE, 10'(bcd_pkg::MODE_MEAN));
    send_pixel(mk_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255), 1'b0);
    send_pixel(mk_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0), 1'b1);
    settle();
    write_reg(bcd_pkg::CFG_MAX_DIFF, 10'd0);
    send_pixel(mk_pair(8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    send_pixel(mk_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0), 1'b0);
    send_pixel(mk_pair(8'd40, 8'd40, 8'd40, 8'd40, 8'd40, 8'd40), 1'b1);

    // exact mode
    settle();
    write_reg(bcd_pkg::CFG_DIFF_MODE, 10'(bcd_pkg::MODE_EXACT));
    send_pixel(mk_pair(8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1);
    send_pixel(mk_pair(8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77), 1'b1);

    // squared mean against a tiny threshold
    settle();
    write_reg(bcd_pkg::CFG_DIFF_MODE, 10'(bcd_pkg::MODE_QMEAN));
    write_reg(bcd_pkg::CFG_MAX_DIFF, 10'd1);
    send_pixel(mk_pair(8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    send_pixel(mk_pair(8'd0, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1);

    // mode switched while a block is open
    settle();
    write_reg(bcd_pkg::CFG_DIFF_MODE, 10'(bcd_pkg::MODE_MEAN));
    write_reg(bcd_pkg::CFG_MAX_DIFF, 10'd10);
    send_pixel(mk_pair(8'd30, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    send_pixel(mk_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    settle();
    write_reg(bcd_pkg::CFG_DIFF_MODE, 10'(bcd_pkg::MODE_QMEAN));
    send_pixel(mk_pair(8'd0, 8'd0, 8'd4, 8'd0, 8'd0, 8'd0), 1'b1);

    // random: four idling phases, several register settings each
    for (int phase = 0; phase < 4; phase++) begin
      for (int setting = 0; setting < SETTINGS_EACH; setting++) begin
        settle();
        case (phase)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
          default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
        mode_pick = (phase * SETTINGS_EACH + setting) % 4;
        case ($urandom_range(3))
          0: threshold = 10'd0;
          1: threshold = 10'd765;
          default: threshold = 10'($urandom_range(765));
        endcase
        if (phase == 0 && setting == 0) threshold = 10'd0;
        if (phase == 0 && setting == 1) threshold = 10'd765;
        write_reg(bcd_pkg::CFG_DIFF_MODE, 10'(bcd_pkg::diff_mode_t'(mode_pick)));
        write_reg(bcd_pkg::CFG_MAX_DIFF, threshold);
        if ($urandom_range(2) == 0)
          write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 10'($urandom));
        setting_sent = 0;
        while (setting_sent < SETTING_PIXELS) begin
          random_block(sent);
          setting_sent += sent;
        end
        // leave a block open so the next setting lands inside it
        if ($urandom_range(2) == 0)
          send_block($urandom_range(1, 10), PAT_NEAR, $urandom_range(255), 1'b0);
      end
    end

    settle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("block_change_detector regression: pass");
    end else begin
      $display("block_change_detector regression: fail");
    end
    $finish;
  end

endmodule
